@@ hw/rtl/fcms_pkg.sv @@
`default_nettype none

package fcms_pkg;

   // Default configuration of the sketch
   localparam int unsigned CODEWORD_LEN_DEFAULT = 64;
   localparam int unsigned INDEX_BITS_DEFAULT   = 8;
   localparam int unsigned ROW_BITS_DEFAULT     = 16;
   localparam int unsigned COL_BITS_DEFAULT     = 10;

   // Function codes of a request
   localparam logic FUNC_QUERY  = 1'b0;
   localparam logic FUNC_UPDATE = 1'b1;

   typedef struct packed {
      logic        func;
      logic [3:0]  bank;
      logic [15:0] row;
      logic [9:0]  col;
      logic [5:0]  err_loc;
      logic        has_error;
   } request_type;

   typedef struct packed {
      logic [5:0] position;
      logic [7:0] min_count;
      logic       last;
   } response_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;     // latch request fields
      logic clear;    // write zero at the clearing address
      logic read;     // read both lines
      logic query;    // read belongs to a query, advance position
      logic write1;   // write back line one
      logic write2;   // write back line two
   } ctrl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic clear_done;
      logic upd_ok;
      logic same_line;
      logic query_last;
   } dp_status_type;

endpackage

`default_nettype wire

@@ hw/rtl/fcms_ctrl.sv @@
`default_nettype none

module fcms_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic                    req_func,
   input  wire fcms_pkg::dp_status_type status,
   output fcms_pkg::ctrl_cmd_type       cmd,
   output logic                         busy
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPD_RD,
      ST_UPD_WR1,
      ST_UPD_WR2,
      ST_QUERY
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;

   // Decode commands and next state
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = (req_func == fcms_pkg::FUNC_UPDATE) ? ST_UPD_RD : ST_QUERY;
            end
         end
         ST_UPD_RD: begin
            cmd.read = 1'b1;
            state_in = status.upd_ok ? ST_UPD_WR1 : ST_IDLE;
         end
         ST_UPD_WR1: begin
            cmd.write1 = 1'b1;
            state_in   = status.same_line ? ST_IDLE : ST_UPD_WR2;
         end
         ST_UPD_WR2: begin
            cmd.write2 = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_QUERY: begin
            cmd.read  = 1'b1;
            cmd.query = 1'b1;
            if (status.query_last) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      busy_in = (state_in != ST_IDLE);
   end

   // Hold state and the busy flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         busy_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

   assign busy = busy_ff;

endmodule

`default_nettype wire

@@ hw/rtl/fcms_datapath.sv @@
`default_nettype none

module fcms_datapath #(
   parameter int unsigned CODEWORD_LEN = fcms_pkg::CODEWORD_LEN_DEFAULT,
   parameter int unsigned INDEX_BITS   = fcms_pkg::INDEX_BITS_DEFAULT,
   parameter int unsigned ROW_BITS     = fcms_pkg::ROW_BITS_DEFAULT,
   parameter int unsigned COL_BITS     = fcms_pkg::COL_BITS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire fcms_pkg::request_type  req_data,
   input  wire fcms_pkg::ctrl_cmd_type cmd,
   output fcms_pkg::dp_status_type     status,
   output logic                        rsp_strobe,
   output fcms_pkg::response_type      rsp_data
);

   localparam int unsigned POS_W  = $clog2(CODEWORD_LEN);
   localparam int unsigned ADDR_W = INDEX_BITS + POS_W;
   localparam int unsigned DEPTH  = 1 << ADDR_W;

   // Counter store: one row of 2^POS_W counters per line
   logic [7:0] mem [DEPTH];

   logic [ROW_BITS-1:0]   row_ext;
   logic [COL_BITS-1:0]   col_ext;
   logic [INDEX_BITS-1:0] line1_in, line2_in;
   logic [INDEX_BITS-1:0] line1_ff, line2_ff;
   logic [5:0]            err_loc_ff;
   logic                  has_error_ff;
   logic [POS_W-1:0]      err_pos;
   logic [POS_W-1:0]      qpos_ff, qpos_in;
   logic [POS_W-1:0]      rd_pos;
   logic [ADDR_W-1:0]     addr1, addr2;
   logic [ADDR_W-1:0]     clr_addr_ff;
   logic [7:0]            rd1_ff, rd2_ff;
   logic                  s1_vld_ff;
   logic [POS_W-1:0]      s1_pos_ff;
   logic                  s1_last_ff;
   logic [8:0]            sum1, sum2;
   logic [7:0]            sat1, sat2;
   logic                  we;
   logic [ADDR_W-1:0]     waddr;
   logic [7:0]            wdata;
   logic                  rsp_strobe_ff;
   fcms_pkg::response_type rsp_ff;

   // Hash the request into its two lines
   always_comb begin
      row_ext  = ROW_BITS'(req_data.row);
      col_ext  = COL_BITS'(req_data.col);
      line1_in = row_ext[ROW_BITS-1 -: INDEX_BITS] ^ col_ext[COL_BITS-1 -: INDEX_BITS];
      line2_in = line1_in ^ INDEX_BITS'(req_data.bank);
   end

   // Latch the request
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         line1_ff     <= line1_in;
         line2_ff     <= line2_in;
         err_loc_ff   <= req_data.err_loc;
         has_error_ff <= req_data.has_error;
      end
   end

   assign err_pos = err_loc_ff[POS_W-1:0];

   // Advance the query position
   always_comb begin
      qpos_in = qpos_ff;
      if (cmd.load)       qpos_in = '0;
      else if (cmd.query) qpos_in = qpos_ff + POS_W'(1);
   end

   always_ff @(posedge clock) begin
      qpos_ff <= qpos_in;
   end

   // Step through the store after reset
   always_ff @(posedge clock) begin
      if (reset)          clr_addr_ff <= '0;
      else if (cmd.clear && clr_addr_ff != {ADDR_W{1'b1}})
         clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
   end

   assign rd_pos = cmd.query ? qpos_ff : err_pos;
   assign addr1  = {line1_ff, rd_pos};
   assign addr2  = {line2_ff, rd_pos};

   // Saturating increments; a shared line gains two
   always_comb begin
      sum1 = {1'b0, rd1_ff} + ((line1_ff == line2_ff) ? 9'd2 : 9'd1);
      sum2 = {1'b0, rd2_ff} + 9'd1;
      sat1 = sum1[8] ? 8'hFF : sum1[7:0];
      sat2 = sum2[8] ? 8'hFF : sum2[7:0];
   end

   always_comb begin
      we    = cmd.clear | cmd.write1 | cmd.write2;
      waddr = cmd.clear ? clr_addr_ff : (cmd.write1 ? addr1 : addr2);
      wdata = cmd.clear ? 8'd0 : (cmd.write1 ? sat1 : sat2);
   end

   // Store write port and both read ports
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rd1_ff <= mem[addr1];
         rd2_ff <= mem[addr2];
      end
   end

   // Track query reads alongside the store
   always_ff @(posedge clock) begin
      if (reset) s1_vld_ff <= 1'b0;
      else       s1_vld_ff <= cmd.query;
      s1_pos_ff  <= qpos_ff;
      s1_last_ff <= (qpos_ff == POS_W'(CODEWORD_LEN - 1));
   end

   // Register the response
   always_ff @(posedge clock) begin
      if (reset) rsp_strobe_ff <= 1'b0;
      else       rsp_strobe_ff <= s1_vld_ff;
      rsp_ff.position  <= 6'(s1_pos_ff);
      rsp_ff.min_count <= (rd1_ff < rd2_ff) ? rd1_ff : rd2_ff;
      rsp_ff.last      <= s1_last_ff;
   end

   always_comb begin
      status.clear_done = (clr_addr_ff == {ADDR_W{1'b1}});
      status.upd_ok     = has_error_ff && ({1'b0, err_loc_ff} < 7'(CODEWORD_LEN));
      status.same_line  = (line1_ff == line2_ff);
      status.query_last = (qpos_ff == POS_W'(CODEWORD_LEN - 1));
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

`default_nettype wire

@@ hw/rtl/fault_count_min_sketch.sv @@
`default_nettype none

// Two-line count-min sketch of per-position fault counters. A request is taken
// when start is high and busy is low. An update (func 1) latches the request,
// reads both lines' counters, then writes once per distinct line, since the
// counter store has a single write port; an update without an error, or with
// err_loc at or beyond CODEWORD_LEN, writes nothing. A query (func 0) reads
// one position per cycle; its CODEWORD_LEN results follow on rsp_strobe, one
// per cycle with no gaps, each passing through the read registers and the
// response register, last marking the final position. The receiver cannot
// stall, so results must be taken on the cycle they appear. After reset the
// store's 2^(INDEX_BITS + clog2(CODEWORD_LEN)) counters (16384 by default) are
// cleared one counter a cycle, with busy held high until it finishes.
module fault_count_min_sketch #(
   parameter int unsigned CODEWORD_LEN = fcms_pkg::CODEWORD_LEN_DEFAULT,
   parameter int unsigned INDEX_BITS   = fcms_pkg::INDEX_BITS_DEFAULT,
   parameter int unsigned ROW_BITS     = fcms_pkg::ROW_BITS_DEFAULT,
   parameter int unsigned COL_BITS     = fcms_pkg::COL_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire fcms_pkg::request_type req_data,
   output logic                       rsp_strobe,
   output fcms_pkg::response_type     rsp_data
);

   fcms_pkg::ctrl_cmd_type  cmd;
   fcms_pkg::dp_status_type status;

   // Sequence the request
   fcms_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_func (req_data.func),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   // Hold the counters and build responses
   fcms_datapath #(
      .CODEWORD_LEN (CODEWORD_LEN),
      .INDEX_BITS   (INDEX_BITS),
      .ROW_BITS     (ROW_BITS),
      .COL_BITS     (COL_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

@@ hw/rtl/fcms_checker.sv @@
`default_nettype none

module fcms_checker #(
   parameter int unsigned CODEWORD_LEN = fcms_pkg::CODEWORD_LEN_DEFAULT
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  start,
   input wire logic                  busy,
   input wire logic                  rsp_strobe,
   input wire fcms_pkg::response_type rsp_data
);

   // No response straight out of reset
   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_strobe)
      else $error("response strobe after reset");

   // A taken request makes the block busy
   a_busy_on_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after request taken");

   // Positions of a query run follow each other without gaps
   a_run_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.last) |=>
         (rsp_strobe && rsp_data.position == $past(rsp_data.position) + 6'd1))
      else $error("query run broken");

   // The final response carries the final position
   a_last_position: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.last) |-> (rsp_data.position == 6'(CODEWORD_LEN - 1)))
      else $error("last flag on wrong position");

   // A run opens at position zero
   a_run_start: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !$past(rsp_strobe && !rsp_data.last)) |-> (rsp_data.position == 6'd0))
      else $error("query run does not start at position zero");

endmodule

bind fault_count_min_sketch fcms_checker #(
   .CODEWORD_LEN (CODEWORD_LEN)
) u_fcms_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

`default_nettype wire
